// File: sv/tsl_pkg.sv
package tsl_pkg;

	localparam int MAX_COLS_DEF    = 4096;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int ELEV_W     = 32;
	localparam int DIFF_W     = 33;
	localparam int SLOPE_W    = 32;
	localparam int ROW_W      = 16;
	localparam int RW_W       = 13;
	localparam int RC_W       = 16;
	localparam int INV_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_EW    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_NS    = 2'd3;

	localparam logic [RW_W-1:0]  ROW_WIDTH_RST = 13'd4096;
	localparam logic [RC_W-1:0]  ROW_COUNT_RST = 16'd65535;
	localparam logic [INV_W-1:0] INV_RST       = 32'h0100_0000;

	localparam logic [SLOPE_W-1:0] SLOPE_SAT = '1;

	// work handed from the front to the arithmetic side
	typedef struct packed {
		logic [DIFF_W-1:0] ad_x;
		logic [DIFF_W-1:0] ad_y;
		logic              calc;
		logic              last_col;
		logic              last_row;
	} tsl_job_t;

	function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [ELEV_W-1:0] a,
		input logic signed [ELEV_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(a) - DIFF_W'(b);
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

endpackage

// File: sv/terrain_slope_3x3.sv
// Streaming 3x3 slope magnitude over a signed elevation raster sent in row-major
// order, one cell per push. For cell (r, c) the result of cell (r-1, c) comes out,
// so row 0 gives nothing and the last row gives two results per cell: the row
// above and its own zero border cell. Interior cells give
// sqrt(dx^2 + dy^2) in unsigned Q16.16, saturated at all ones, with dx, dy the
// central differences scaled by the Q8.24 reciprocal registers; border cells give
// zero. frame_start on a cell puts the position back to row 0, column 0.
// Flow: the front takes one cell at a time and no new one until it is written
// back (line buffer read then write back, one 64-bit two-read-port RAM); past
// row 0 it stalls while the job queue is full. The arithmetic back end only
// emits for a border cell (twice on the last row, for the flushed zero), skips
// the square root when a scaled difference or the sum of squares saturates, and
// runs 4 partial products, 2 squares, a sum, a 32-step bit-serial square root,
// then output for an interior cell, so the sustained rate is set by the square
// root. Output waits while the receiver holds the last result. A short job
// queue lets the front run ahead of the back end. Registers must be written only
// while the block is idle; the block does not enforce this. No clearing pass after reset.
module terrain_slope_3x3
	import tsl_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic signed [ELEV_W-1:0] elevation,
	input  logic                     frame_start,
	output logic                     empty,
	input  logic                     pop,
	output logic [SLOPE_W-1:0]       slope,
	output logic                     end_of_row,
	output logic                     end_of_frame
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [RW_W-1:0]  row_width_q;
	logic [RC_W-1:0]  row_count_q;
	logic [INV_W-1:0] inv_ew_q, inv_ns_q;

	logic [CW-1:0]         raddr_a, raddr_b, waddr;
	logic [2*ELEV_W-1:0]   rdata_a, rdata_b, wdata;
	logic                  we;
	tsl_job_t              job_in, job_out;
	logic                  job_valid, q_full, q_empty, job_pop;

	// configuration: plain write port, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			row_count_q <= ROW_COUNT_RST;
			inv_ew_q    <= INV_RST;
			inv_ns_q    <= INV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_data[RW_W-1:0];
				REG_ROW_COUNT: row_count_q <= cfg_data[RC_W-1:0];
				REG_INV_EW:    inv_ew_q    <= cfg_data[INV_W-1:0];
				REG_INV_NS:    inv_ns_q    <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// line buffers: upper half holds the row two back, lower half the row above
	tsl_ram #(
		.WIDTH(2 * ELEV_W),
		.DEPTH(MAX_COLS)
	) u_lines (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// front: position tracking, window fetch, border classification
	tsl_front #(
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.elevation   (elevation),
		.frame_start (frame_start),
		.row_width   (row_width_q),
		.row_count   (row_count_q),
		.raddr_a     (raddr_a),
		.raddr_b     (raddr_b),
		.rdata_a     (rdata_a),
		.rdata_b     (rdata_b),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.job_valid   (job_valid),
		.job_ready   (!q_full),
		.job         (job_in)
	);

	tsl_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid && !q_full),
		.wr_data (job_in),
		.full_o  (q_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty_o (q_empty)
	);

	// back end: scaling, squares, square root, result transactions
	tsl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (!q_empty),
		.job_pop      (job_pop),
		.job          (job_out),
		.inv_ew       (inv_ew_q),
		.inv_ns       (inv_ns_q),
		.empty        (empty),
		.pop          (pop),
		.slope        (slope),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: sv/tsl_ram.sv
module tsl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_a,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                     rdata_a,
	output logic [WIDTH-1:0]                     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: sv/tsl_front.sv
module tsl_front
	import tsl_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       push,
	output logic                                       full,
	input  logic signed [ELEV_W-1:0]                   elevation,
	input  logic                                       frame_start,
	input  logic [RW_W-1:0]                            row_width,
	input  logic [RC_W-1:0]                            row_count,
	output logic [(MAX_COLS>1?$clog2(MAX_COLS):1)-1:0] raddr_a,
	output logic [(MAX_COLS>1?$clog2(MAX_COLS):1)-1:0] raddr_b,
	input  logic [2*ELEV_W-1:0]                        rdata_a,
	input  logic [2*ELEV_W-1:0]                        rdata_b,
	output logic                                       we,
	output logic [(MAX_COLS>1?$clog2(MAX_COLS):1)-1:0] waddr,
	output logic [2*ELEV_W-1:0]                        wdata,
	output logic                                       job_valid,
	input  logic                                       job_ready,
	output tsl_job_t                                   job
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [16:0] MaxColsW = 17'(MAX_COLS);
	localparam logic [CW-1:0] LastAddr = CW'(MAX_COLS - 1);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_READ = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [CW-1:0]    col_q, c_s1, c_now, addr;
	logic [ROW_W-1:0] row_q, r_s1, r_now;
	logic signed [ELEV_W-1:0] elev_s1;
	logic [ELEV_W-1:0] win0_q, mid_c, mid_n, upper_c;
	logic [16:0] w_eff, h_eff, c17, r17;
	logic last_col, last_row, advance, accept;

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign c_now  = frame_start ? '0 : col_q;
	assign r_now  = frame_start ? '0 : row_q;
	assign addr   = (state_q == F_IDLE) ? c_now : c_s1;

	assign raddr_a = addr;
	assign raddr_b = (addr == LastAddr) ? '0 : addr + 1'b1;

	always_comb begin
		if (row_width < RW_W'(3)) begin
			w_eff = 17'd3;
		end else if (17'(row_width) > MaxColsW) begin
			w_eff = MaxColsW;
		end else begin
			w_eff = 17'(row_width);
		end
		h_eff = (row_count < RC_W'(3)) ? 17'd3 : 17'(row_count);
	end

	assign c17      = 17'(c_s1);
	assign r17      = 17'(r_s1);
	assign last_col = c17 >= w_eff - 17'd1;
	assign last_row = r17 >= h_eff - 17'd1;

	assign mid_c   = rdata_a[ELEV_W-1:0];
	assign upper_c = rdata_a[2*ELEV_W-1:ELEV_W];
	// the cell east of the last possible column does not exist
	assign mid_n   = (c_s1 == LastAddr) ? '0 : rdata_b[ELEV_W-1:0];

	always_comb begin
		job.ad_x     = abs_diff($signed(mid_n), $signed(win0_q));
		job.ad_y     = abs_diff(elev_s1, $signed(upper_c));
		job.calc     = (r17 >= 17'd2) && !last_col && (c17 >= 17'd1) && (r17 < h_eff);
		job.last_col = last_col;
		job.last_row = last_row;
	end

	// nothing is emitted while the first row arrives
	assign job_valid = (state_q == F_READ) && (r_s1 != '0);
	assign advance   = (state_q == F_READ) && ((r_s1 == '0) || job_ready);

	assign we    = advance;
	assign waddr = c_s1;
	assign wdata = {mid_c, elev_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			win0_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_READ;
					end
				end
				F_READ: begin
					if (advance) begin
						state_q <= F_IDLE;
						win0_q  <= mid_c;
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : r_s1 + 1'b1;
						end else begin
							col_q <= c_s1 + 1'b1;
							row_q <= r_s1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1    <= c_now;
			r_s1    <= r_now;
			elev_s1 <= elevation;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> full) else $error("front not busy after accept");
	a_write_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == F_READ) else $error("line write outside read state");
`endif

endmodule

// File: sv/tsl_fifo.sv
module tsl_fifo
	import tsl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  tsl_job_t wr_data,
	output logic     full_o,
	input  logic     rd_en,
	output tsl_job_t rd_data,
	output logic     empty_o
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	tsl_job_t slot_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full_o  = (cnt_q == NW'(DEPTH));
	assign empty_o = (cnt_q == '0);
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full_o) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty_o) else $error("job queue underflow");
`endif

endmodule

// File: sv/tsl_back.sv
module tsl_back
	import tsl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_pop,
	input  tsl_job_t           job,
	input  logic [INV_W-1:0]   inv_ew,
	input  logic [INV_W-1:0]   inv_ns,
	output logic               empty,
	input  logic               pop,
	output logic [SLOPE_W-1:0] slope,
	output logic               end_of_row,
	output logic               end_of_frame
);

	typedef enum logic [9:0] {
		B_IDLE = 10'b00_0000_0001,
		B_MXL  = 10'b00_0000_0010,
		B_MXH  = 10'b00_0000_0100,
		B_MYL  = 10'b00_0000_1000,
		B_MYH  = 10'b00_0001_0000,
		B_SQX  = 10'b00_0010_0000,
		B_SQY  = 10'b00_0100_0000,
		B_SUM  = 10'b00_1000_0000,
		B_ROOT = 10'b01_0000_0000,
		B_EMIT = 10'b10_0000_0000
	} back_state_t;

	back_state_t state_q;
	tsl_job_t job_q;
	logic [DIFF_W+15:0] mul_lo_q, prod;
	logic [DIFF_W-1:0]  mul_a;
	logic [15:0]        mul_b;
	logic [INV_W-1:0]   inv_sel;
	logic [64:0]        pfull;
	logic [31:0]        dx_q, dy_q, res_slope_q;
	logic               ovf_q, phase_q;
	logic [63:0]        sx_q, sy_q, v_q, res_q, bit_q, trial, res_next;
	logic [64:0]        sum;
	logic [4:0]         cnt_q;
	logic               out_valid_q, out_free, sel_x, sel_lo;

	assign sel_x   = (state_q == B_MXL) || (state_q == B_MXH);
	assign sel_lo  = (state_q == B_MXL) || (state_q == B_MYL);
	assign mul_a   = sel_x ? job_q.ad_x : job_q.ad_y;
	assign inv_sel = sel_x ? inv_ew : inv_ns;
	assign mul_b   = sel_lo ? inv_sel[15:0] : inv_sel[31:16];
	assign prod    = (DIFF_W + 16)'(mul_a) * (DIFF_W + 16)'(mul_b);
	assign pfull   = {prod, 16'b0} + 65'(mul_lo_q);

	assign sum      = {1'b0, sx_q} + {1'b0, sy_q};
	assign trial    = res_q + bit_q;
	assign res_next = (v_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1;

	assign out_free = !out_valid_q || pop;
	assign job_pop  = (state_q == B_IDLE) && job_valid;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						phase_q <= 1'b0;
						state_q <= job.calc ? B_MXL : B_EMIT;
					end
				end
				B_MXL:  state_q <= B_MXH;
				B_MXH:  state_q <= B_MYL;
				B_MYL:  state_q <= B_MYH;
				B_MYH:  state_q <= B_SQX;
				B_SQX:  state_q <= B_SQY;
				B_SQY:  state_q <= B_SUM;
				B_SUM:  state_q <= (ovf_q || sum[64]) ? B_EMIT : B_ROOT;
				B_ROOT: begin
					if (cnt_q == 5'd31) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!phase_q && job_q.last_row) begin
							phase_q <= 1'b1;
						end else begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				job_q       <= job;
				ovf_q       <= 1'b0;
				res_slope_q <= '0;
			end
			B_MXL, B_MYL: mul_lo_q <= prod;
			B_MXH: begin
				dx_q  <= pfull[39:8];
				ovf_q <= ovf_q | (|pfull[64:40]);
			end
			B_MYH: begin
				dy_q  <= pfull[39:8];
				ovf_q <= ovf_q | (|pfull[64:40]);
			end
			B_SQX: sx_q <= 64'(dx_q) * 64'(dx_q);
			B_SQY: sy_q <= 64'(dy_q) * 64'(dy_q);
			B_SUM: begin
				v_q         <= sum[63:0];
				res_q       <= '0;
				bit_q       <= 64'h4000_0000_0000_0000;
				cnt_q       <= '0;
				res_slope_q <= SLOPE_SAT;
			end
			B_ROOT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
				end
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					res_slope_q <= res_next[31:0];
				end
			end
			B_EMIT: begin
				if (out_free) begin
					slope        <= phase_q ? '0 : res_slope_q;
					end_of_row   <= job_q.last_col;
					end_of_frame <= phase_q && job_q.last_col;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_eof_has_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_of_frame |-> end_of_row) else $error("frame end off row end");
	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q != B_IDLE) else $error("job taken but not started");
`endif

endmodule

// File: tb/tb_terrain_slope_3x3.sv
module tb_terrain_slope_3x3;
	import tsl_pkg::*;

	// idle limit: longest receiver hold-off plus back-end latency, several times over
	localparam int IDLE_LIMIT   = 20000;
	// quiet time before a register write: the front may still be writing back a
	// row-0 cell, which gives no result
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 3000;
	localparam int RESET_ITEMS  = 40;
	localparam int RANDOM_ITEMS = 1790;
	// cells in one random phase at most; a cut frame is a legal stream
	localparam int PHASE_CAP    = 300;

	typedef struct {
		logic [SLOPE_W-1:0] slope;
		logic               eor;
		logic               eof;
	} slope_rec_t;

	typedef struct {
		logic signed [ELEV_W-1:0] elev;
		logic                     fs;
		logic                     has_want;
		logic [SLOPE_W-1:0]       want;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     push = 1'b0;
	logic                     full;
	logic signed [ELEV_W-1:0] elevation = '0;
	logic                     frame_start = 1'b0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic [SLOPE_W-1:0]       slope;
	logic                     end_of_row;
	logic                     end_of_frame;

	terrain_slope_3x3 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.elevation    (elevation),
		.frame_start  (frame_start),
		.empty        (empty),
		.pop          (pop),
		.slope        (slope),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Slope predictor: own copy of line buffers, window, position and registers
	// ---------------------------------------------------------------------
	logic [ELEV_W-1:0]  upper_m  [MAX_COLS_DEF];
	logic [ELEV_W-1:0]  middle_m [MAX_COLS_DEF];
	logic [ELEV_W-1:0]  win_west;
	logic [ROW_W-1:0]   pos_row;
	logic [11:0]        pos_col;
	logic [RW_W-1:0]    width_reg;
	logic [RC_W-1:0]    rows_reg;
	logic [INV_W-1:0]   inv_ew_reg;
	logic [INV_W-1:0]   inv_ns_reg;

	slope_rec_t slopes_due[$];
	int errors = 0;

	function automatic logic [DIFF_W-1:0] elev_gap(input logic [ELEV_W-1:0] a,
		input logic [ELEV_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[ELEV_W-1], a}) - $signed({b[ELEV_W-1], b});
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	// floor of the square root, bit by bit
	function automatic logic [31:0] root64(input logic [63:0] v);
		logic [63:0] rem, res, bitv;
		rem  = v;
		res  = '0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	// Q8.24 scaling truncated to Q16.16, then the magnitude; saturates
	function automatic logic [SLOPE_W-1:0] slope_mag(input logic [DIFF_W-1:0] adx,
		input logic [DIFF_W-1:0] ady);
		logic [64:0] dx, dy, sum;
		logic [63:0] sx, sy;
		dx = (65'(adx) * 65'(inv_ew_reg)) >> 8;
		dy = (65'(ady) * 65'(inv_ns_reg)) >> 8;
		if (dx[64:32] != 0 || dy[64:32] != 0)
			return SLOPE_SAT;
		sx  = 64'(dx[31:0]) * 64'(dx[31:0]);
		sy  = 64'(dy[31:0]) * 64'(dy[31:0]);
		sum = 65'(sx) + 65'(sy);
		if (sum[64])
			return SLOPE_SAT;
		return root64(sum[63:0]);
	endfunction

	// one accepted cell: queue the results it causes, advance the position
	task automatic model_cell(input logic [ELEV_W-1:0] e, input logic fs);
		int w, h, r, c;
		logic last_col, last_row;
		logic [ELEV_W-1:0] win_mid, win_east;
		slope_rec_t rec;
		w = width_reg < 3 ? 3 : (width_reg > MAX_COLS_DEF ? MAX_COLS_DEF : int'(width_reg));
		h = rows_reg < 3 ? 3 : int'(rows_reg);
		if (fs) begin
			pos_row = '0;
			pos_col = '0;
		end
		r = pos_row;
		c = pos_col;
		last_col = c >= w - 1;
		last_row = r >= h - 1;
		win_mid  = middle_m[c];
		win_east = (c + 1 < MAX_COLS_DEF) ? middle_m[c + 1] : '0;
		if (r >= 1) begin
			rec.slope = '0;
			if (r >= 2 && !last_col && c >= 1 && r - 1 < h - 1)
				rec.slope = slope_mag(elev_gap(win_east, win_west), elev_gap(e, upper_m[c]));
			rec.eor = last_col;
			rec.eof = 1'b0;
			slopes_due.push_back(rec);
			// last row: its own zero border row is flushed alongside
			if (last_row) begin
				rec.slope = '0;
				rec.eor   = last_col;
				rec.eof   = last_col;
				slopes_due.push_back(rec);
			end
		end
		upper_m[c]  = win_mid;
		middle_m[c] = e;
		win_west    = win_mid;
		if (last_col) begin
			pos_col = '0;
			pos_row = last_row ? '0 : ROW_W'(r + 1);
		end else begin
			pos_col = 12'(c + 1);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driving side
	// ---------------------------------------------------------------------
	int burst_left = 0;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// offers one cell until the block takes it; optional typed slope for the first result
	task automatic send_cell(input logic [ELEV_W-1:0] e, input logic fs,
		input logic has_want = 1'b0, input logic [SLOPE_W-1:0] want = '0);
		int gap, first;
		if (gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		push        <= 1'b1;
		elevation   <= e;
		frame_start <= fs;
		do @(posedge clk); while (full);
		if (burst_left > 0)
			burst_left--;
		first = slopes_due.size();
		model_cell(e, fs);
		if (has_want && slopes_due.size() > first)
			slopes_due[first].slope = want;
	endtask

	// block is quiet: nothing queued and the back end had time to finish
	task automatic wait_idle();
		push <= 1'b0;
		while (slopes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROW_WIDTH: width_reg  = d[RW_W-1:0];
			REG_ROW_COUNT: rows_reg   = d[RC_W-1:0];
			REG_INV_EW:    inv_ew_reg = d;
			REG_INV_NS:    inv_ns_reg = d;
		endcase
	endtask

	function automatic logic [ELEV_W-1:0] pick_elev(input int style);
		case ($urandom_range(0, 7))
			0:       return $urandom();
			1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return (style == 0) ? ELEV_W'($urandom_range(0, 2000) - 1000)
				: ELEV_W'($urandom_range(0, 200000) - 100000);
		endcase
	endfunction

	function automatic logic [INV_W-1:0] pick_inv();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return $urandom();
			3:       return INV_RST;
			default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Receiving side: stall pattern re-chosen at random, plus one long hold
	// ---------------------------------------------------------------------
	int rx_cycle = 0;
	int rx_mode = 0;

	always @(posedge clk) begin : rx_side
		slope_rec_t want;
		if (pop && !empty) begin
			if (slopes_due.size() == 0) begin
				report_mismatch("result with none due", slope, '0);
			end else begin
				want = slopes_due.pop_front();
				if (slope !== want.slope)
					report_mismatch("slope", slope, want.slope);
				if (end_of_row !== want.eor)
					report_mismatch("end_of_row", 32'(end_of_row), 32'(want.eor));
				if (end_of_frame !== want.eof)
					report_mismatch("end_of_frame", 32'(end_of_frame), 32'(want.eof));
			end
		end
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 256 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0:       pop <= !hold;
			1:       pop <= !hold && $urandom_range(0, 1);
			2:       pop <= !hold && (rx_cycle % 4 == 0);
			default: pop <= !hold && ($urandom_range(0, 9) != 0);
		endcase
	end

	// long hold-off while the sender keeps offering, so the block fills and stalls
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold <= 1'b0;
	end

	// watchdog: cycles with no transaction on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	dir_row_t dir_tab[21];

	initial begin
		int rand_items, phase, w, h, cells, frames, style, i;
		logic fs;
		for (i = 0; i < MAX_COLS_DEF; i++) begin
			upper_m[i]  = '0;
			middle_m[i] = '0;
		end
		win_west   = '0;
		pos_row    = '0;
		pos_col    = '0;
		width_reg  = ROW_WIDTH_RST;
		rows_reg   = ROW_COUNT_RST;
		inv_ew_reg = INV_RST;
		inv_ns_reg = INV_RST;

		// 3x3 frames: one saturating interior cell, one 3-4-5 cell, then a broken frame
		dir_tab = '{
			'{32'sd100, 1'b1, 1'b0, '0}, '{-32'sd100, 1'b0, 1'b0, '0}, '{32'sd0, 1'b0, 1'b0, '0},
			'{32'sh8000_0000, 1'b0, 1'b0, '0}, '{32'sd17, 1'b0, 1'b0, '0},
			'{32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
			'{32'sd0, 1'b0, 1'b0, '0}, '{32'sd12, 1'b0, 1'b1, SLOPE_SAT}, '{32'sd0, 1'b0, 1'b0, '0},
			'{32'sd0, 1'b1, 1'b0, '0}, '{32'sd5, 1'b0, 1'b0, '0}, '{32'sd0, 1'b0, 1'b0, '0},
			'{32'sd3, 1'b0, 1'b0, '0}, '{32'sd0, 1'b0, 1'b0, '0}, '{32'sd7, 1'b0, 1'b0, '0},
			'{32'sd0, 1'b0, 1'b0, '0}, '{32'sd8, 1'b0, 1'b1, 32'h0005_0000},
			'{32'sd0, 1'b0, 1'b0, '0},
			'{32'sd42, 1'b1, 1'b0, '0}, '{32'sd43, 1'b0, 1'b0, '0}, '{32'sd44, 1'b1, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: the first cells of row 0 give no result at all
		gaps_on = 1'b0;
		for (i = 0; i < RESET_ITEMS; i++)
			send_cell(pick_elev(0), i == 0);
		wait_idle();

		gaps_on = 1'b1;
		write_reg(REG_ROW_WIDTH, 32'd3);
		write_reg(REG_ROW_COUNT, 32'd3);
		write_reg(REG_INV_EW, INV_RST);
		write_reg(REG_INV_NS, INV_RST);
		foreach (dir_tab[k])
			send_cell(dir_tab[k].elev, dir_tab[k].fs, dir_tab[k].has_want, dir_tab[k].want);
		wait_idle();

		// random phases: mostly well-formed frames, some broken by early frame_start
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       w = $urandom_range(0, 2);
				1:       w = $urandom_range(20, 64);
				default: w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0:       h = 65535;
				1:       h = $urandom_range(0, 2);
				default: h = $urandom_range(3, 7);
			endcase
			write_reg(REG_ROW_WIDTH, 32'(w));
			write_reg(REG_ROW_COUNT, 32'(h));
			write_reg(REG_INV_EW, pick_inv());
			write_reg(REG_INV_NS, pick_inv());
			w = w < 3 ? 3 : w;
			h = h < 3 ? 3 : h;
			frames = $urandom_range(1, 3);
			cells = (h > 8) ? w * 5 : frames * w * h;
			if (cells > PHASE_CAP)
				cells = PHASE_CAP;
			if (cells > RANDOM_ITEMS - rand_items)
				cells = RANDOM_ITEMS - rand_items;
			gaps_on = (phase % 5 != 1);
			style = $urandom_range(0, 1);
			if (phase == 4)
				hold_req = 1'b1;
			for (i = 0; i < cells; i++) begin
				// row count shrinks mid-frame once: position may sit past the last row
				if (phase == 2 && i == cells / 2) begin
					wait_idle();
					write_reg(REG_ROW_COUNT, 32'($urandom_range(0, 4)));
				end
				if (i == 0)
					fs = 1'b1;
				else if (i % (w * h) == 0)
					fs = $urandom_range(0, 9) < 7;
				else
					fs = $urandom_range(0, 99) < 3;
				send_cell(pick_elev(style), fs);
				rand_items++;
			end
			wait_idle();
			phase++;
		end

		push <= 1'b0;
		while (slopes_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
